FILE: rtl/assert_macros.svh
// assertion macros used by the motor mixer top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked out of reset
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/mmx_pkg.sv
// types, constants and mixing tables of the motor mixer
`timescale 1ns / 1ps

package mmx_pkg;

  localparam int MaxMotors       = 8;
  localparam int DisarmedCommand = 1000;
  localparam int NumFrames       = 12;
  localparam int FrameSlots      = 8;

  localparam int ValueW   = 11;
  localparam int PidW     = 11;
  localparam int YawCmdW  = 10;
  localparam int IndexW   = 3;
  localparam int FrameW   = 4;
  localparam int CountW   = 4;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 11;

  // fixed-point reciprocal scaling for the fractional coefficients
  localparam int FracShift = 14;
  localparam int CoefW     = 15;
  localparam int QuotW     = 12;
  localparam int TermW     = 13;
  localparam int YawW      = 12;
  localparam int SumW      = 15;

  localparam int YawClampBase = 100;

  // reset values of the configuration registers
  localparam logic [FrameW-1:0] FrameTypeRst   = FrameW'(3);
  localparam logic [ValueW-1:0] MinThrottleRst = ValueW'(1150);
  localparam logic [ValueW-1:0] MaxThrottleRst = ValueW'(1850);
  localparam logic [ValueW-1:0] MinCheckRst    = ValueW'(1100);
  localparam logic [ValueW-1:0] StopCommandRst = ValueW'(1000);

  typedef enum logic [CfgIdxW-1:0] {
    RegFrameType,
    RegYawReverse,
    RegMinThrottle,
    RegMaxThrottle,
    RegMinCheck,
    RegMotorStop,
    RegStopCommand
  } cfg_reg_e;

  typedef enum logic [2:0] {
    RatioZero,
    RatioOne,
    RatioHalf,
    RatioFourThirds,
    RatioTwoThirds,
    RatioFourFifths,
    RatioNineTenths,
    RatioSevenTenths
  } ratio_e;

  typedef struct packed {
    logic   rneg;
    ratio_e rr;
    logic   pneg;
    ratio_e pr;
    logic   yneg;
    logic   yen;
  } mix_t;

  // magnitude n/d to ratio code
  function automatic ratio_e ratio_of(int n, int d);
    int an;
    an = (n < 0) ? -n : n;
    if (an == 0) return RatioZero;
    if (an == d) return RatioOne;
    if (2 * an == d) return RatioHalf;
    if (an == 4 && d == 3) return RatioFourThirds;
    if (an == 2 && d == 3) return RatioTwoThirds;
    if (an == 4 && d == 5) return RatioFourFifths;
    if (an == 9 && d == 10) return RatioNineTenths;
    return RatioSevenTenths;
  endfunction

  // one motor's coefficients written as in the frame definitions
  function automatic mix_t mc(int rn, int rd, int pn, int pd, int yz);
    mix_t m;
    m.rneg = (rn < 0);
    m.rr   = ratio_of(rn, rd);
    m.pneg = (pn < 0);
    m.pr   = ratio_of(pn, pd);
    m.yneg = (yz < 0);
    m.yen  = (yz != 0);
    return m;
  endfunction

  // ceil(ratio * 2^FracShift), exact floor for magnitudes up to 1024
  function automatic logic [CoefW-1:0] ratio_mag(ratio_e r);
    logic [CoefW-1:0] k;
    unique case (r)
      RatioZero:        k = CoefW'(0);
      RatioOne:         k = CoefW'(16384);
      RatioHalf:        k = CoefW'(8192);
      RatioFourThirds:  k = CoefW'(21846);
      RatioTwoThirds:   k = CoefW'(10923);
      RatioFourFifths:  k = CoefW'(13108);
      RatioNineTenths:  k = CoefW'(14746);
      RatioSevenTenths: k = CoefW'(11469);
      default:          k = CoefW'(0);
    endcase
    return k;
  endfunction

  localparam logic [CountW-1:0] FrameCount [NumFrames] = '{
    CountW'(2), CountW'(3), CountW'(4), CountW'(4), CountW'(4), CountW'(6),
    CountW'(6), CountW'(6), CountW'(8), CountW'(8), CountW'(8), CountW'(4)
  };

  localparam mix_t MixTable [NumFrames][FrameSlots] = '{
    // bi
    '{mc(1,1,0,1,0), mc(-1,1,0,1,0), mc(0,1,0,1,0), mc(0,1,0,1,0),
      mc(0,1,0,1,0), mc(0,1,0,1,0), mc(0,1,0,1,0), mc(0,1,0,1,0)},
    // tri
    '{mc(0,1,4,3,0), mc(-1,1,-2,3,0), mc(1,1,-2,3,0), mc(0,1,0,1,0),
      mc(0,1,0,1,0), mc(0,1,0,1,0), mc(0,1,0,1,0), mc(0,1,0,1,0)},
    // quad plus
    '{mc(0,1,1,1,-1), mc(-1,1,0,1,1), mc(1,1,0,1,1), mc(0,1,-1,1,-1),
      mc(0,1,0,1,0), mc(0,1,0,1,0), mc(0,1,0,1,0), mc(0,1,0,1,0)},
    // quad x
    '{mc(-1,1,1,1,-1), mc(-1,1,-1,1,1), mc(1,1,1,1,1), mc(1,1,-1,1,-1),
      mc(0,1,0,1,0), mc(0,1,0,1,0), mc(0,1,0,1,0), mc(0,1,0,1,0)},
    // y4
    '{mc(0,1,1,1,-1), mc(-1,1,-1,1,0), mc(0,1,1,1,1), mc(1,1,-1,1,0),
      mc(0,1,0,1,0), mc(0,1,0,1,0), mc(0,1,0,1,0), mc(0,1,0,1,0)},
    // y6
    '{mc(0,1,4,3,1), mc(-1,1,-2,3,-1), mc(1,1,-2,3,-1), mc(0,1,4,3,-1),
      mc(-1,1,-2,3,1), mc(1,1,-2,3,1), mc(0,1,0,1,0), mc(0,1,0,1,0)},
    // hex plus
    '{mc(-1,2,1,2,1), mc(-1,2,-1,2,-1), mc(1,2,1,2,1), mc(1,2,-1,2,-1),
      mc(0,1,-1,1,1), mc(0,1,1,1,-1), mc(0,1,0,1,0), mc(0,1,0,1,0)},
    // hex x
    '{mc(-4,5,9,10,1), mc(-4,5,-9,10,1), mc(4,5,9,10,-1), mc(4,5,-9,10,-1),
      mc(-4,5,0,1,-1), mc(4,5,0,1,1), mc(0,1,0,1,0), mc(0,1,0,1,0)},
    // octo x8
    '{mc(-1,1,1,1,-1), mc(-1,1,-1,1,1), mc(1,1,1,1,1), mc(1,1,-1,1,-1),
      mc(-1,1,1,1,1), mc(-1,1,-1,1,-1), mc(1,1,1,1,-1), mc(1,1,-1,1,1)},
    // octo flat plus
    '{mc(7,10,-7,10,1), mc(-7,10,-7,10,1), mc(-7,10,7,10,1), mc(7,10,7,10,1),
      mc(0,1,-1,1,-1), mc(-1,1,0,1,-1), mc(0,1,1,1,-1), mc(1,1,0,1,-1)},
    // octo flat x
    '{mc(1,1,-1,2,1), mc(-1,2,-1,1,1), mc(-1,1,1,2,1), mc(1,2,1,1,1),
      mc(1,2,-1,1,-1), mc(-1,1,-1,2,-1), mc(-1,2,1,1,-1), mc(1,1,1,2,-1)},
    // vtail4
    '{mc(0,1,1,1,1), mc(-1,1,-1,1,0), mc(0,1,1,1,-1), mc(1,1,-1,1,0),
      mc(0,1,0,1,0), mc(0,1,0,1,0), mc(0,1,0,1,0), mc(0,1,0,1,0)}
  };

endpackage

FILE: rtl/mmx_if.sv
// request, result and configuration channel interfaces of the motor mixer
`timescale 1ns / 1ps

interface mmx_req_if;
  import mmx_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [ValueW-1:0]          throttle_command;
  logic signed [PidW-1:0]     throttle_pid;
  logic signed [PidW-1:0]     roll_pid;
  logic signed [PidW-1:0]     pitch_pid;
  logic signed [PidW-1:0]     yaw_pid;
  logic signed [YawCmdW-1:0]  yaw_command;
  logic [ValueW-1:0]          stick_throttle;
  logic                       armed;

  modport source (
    output valid, throttle_command, throttle_pid, roll_pid, pitch_pid, yaw_pid,
           yaw_command, stick_throttle, armed,
    input  ready
  );
  modport sink (
    input  valid, throttle_command, throttle_pid, roll_pid, pitch_pid, yaw_pid,
           yaw_command, stick_throttle, armed,
    output ready
  );
endinterface

interface mmx_res_if;
  import mmx_pkg::*;

  logic              valid;
  logic              ready;
  logic [IndexW-1:0] motor_index;
  logic [ValueW-1:0] motor_value;
  logic              last_motor;

  modport source (
    output valid, motor_index, motor_value, last_motor,
    input  ready
  );
  modport sink (
    input  valid, motor_index, motor_value, last_motor,
    output ready
  );
endinterface

interface mmx_cfg_if;
  import mmx_pkg::*;

  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

FILE: rtl/multirotor_motor_mixer.sv
// multirotor motor mixer top level: one request in, one command per motor out
// a request passes the stage 0 to 3 registers into the result buffer
// throughput: the single result port sends the motors one per cycle while ready,
//   which limits the request rate by the motor count of the frame (2 to 8)
// reset: asynchronous active low, pipeline empty, registers at their defaults
`timescale 1ns / 1ps

`include "assert_macros.svh"

module multirotor_motor_mixer #(
  parameter int MAX_MOTORS       = mmx_pkg::MaxMotors,
  parameter int DISARMED_COMMAND = mmx_pkg::DisarmedCommand
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  mmx_cfg_if.sink          cfg_i,
  mmx_req_if.sink          req_i,
  mmx_res_if.source        res_o
);
  import mmx_pkg::*;

  localparam int LaneIdxW = $clog2(MAX_MOTORS);

  // configuration registers
  logic [FrameW-1:0] frame_type_q;
  logic              yaw_reverse_q;
  logic [ValueW-1:0] min_throttle_q;
  logic [ValueW-1:0] max_throttle_q;
  logic [ValueW-1:0] min_check_q;
  logic              motor_stop_q;
  logic [ValueW-1:0] stop_command_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_type_q   <= FrameTypeRst;
      yaw_reverse_q  <= 1'b0;
      min_throttle_q <= MinThrottleRst;
      max_throttle_q <= MaxThrottleRst;
      min_check_q    <= MinCheckRst;
      motor_stop_q   <= 1'b0;
      stop_command_q <= StopCommandRst;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        RegFrameType:   frame_type_q   <= cfg_i.data[FrameW-1:0];
        RegYawReverse:  yaw_reverse_q  <= cfg_i.data[0];
        RegMinThrottle: min_throttle_q <= cfg_i.data[ValueW-1:0];
        RegMaxThrottle: max_throttle_q <= cfg_i.data[ValueW-1:0];
        RegMinCheck:    min_check_q    <= cfg_i.data[ValueW-1:0];
        RegMotorStop:   motor_stop_q   <= cfg_i.data[0];
        RegStopCommand: stop_command_q <= cfg_i.data[ValueW-1:0];
        default: ;
      endcase
    end
  end

  // pipeline handshake chain
  logic v0_q, v1_q, v2_q, v3_q, bv_q;
  logic r0, r1, r2, r3, bfree;
  logic req_fire, res_fire, res_last;

  assign res_fire = res_o.valid && res_o.ready;
  assign bfree    = !bv_q || (res_fire && res_last);
  assign r3       = !v3_q || bfree;
  assign r2       = !v2_q || r3;
  assign r1       = !v1_q || r2;
  assign r0       = !v0_q || r1;
  assign req_fire = req_i.valid && r0;

  assign req_i.ready = r0;

  // frame decode at request time
  logic                frame_ok;
  logic [CountW-1:0]   frame_cnt;
  logic [CountW-1:0]   eff_cnt;
  logic [LaneIdxW-1:0] last_idx;

  always_comb begin
    frame_ok  = (frame_type_q < FrameW'(NumFrames));
    frame_cnt = frame_ok ? FrameCount[frame_type_q] : CountW'(0);
    eff_cnt   = (frame_cnt > CountW'(MAX_MOTORS)) ? CountW'(MAX_MOTORS) : frame_cnt;
    last_idx  = LaneIdxW'(eff_cnt - CountW'(1));
  end

  // stage 0: request register
  logic [ValueW-1:0]         s0_thr_q;
  logic signed [PidW-1:0]    s0_tpid_q, s0_roll_q, s0_pitch_q, s0_yaw_q;
  logic signed [YawCmdW-1:0] s0_ycmd_q;
  logic                      s0_low_q, s0_armed_q, s0_multi_q;
  logic [FrameW-1:0]         s0_frame_q;
  logic [LaneIdxW-1:0]       s0_last_q;

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      s0_thr_q   <= req_i.throttle_command;
      s0_tpid_q  <= req_i.throttle_pid;
      s0_roll_q  <= req_i.roll_pid;
      s0_pitch_q <= req_i.pitch_pid;
      s0_yaw_q   <= req_i.yaw_pid;
      s0_ycmd_q  <= req_i.yaw_command;
      s0_low_q   <= (req_i.stick_throttle < min_check_q);
      s0_armed_q <= req_i.armed;
      s0_multi_q <= (frame_cnt > CountW'(3));
      s0_frame_q <= frame_type_q;
      s0_last_q  <= last_idx;
    end
  end

  // stage 1: yaw clamp and per-motor coefficient products
  logic [PidW-1:0]         roll_mag, pitch_mag;
  logic [YawCmdW-1:0]      ycmd_abs;
  logic signed [YawW-1:0]  yaw_lim, yaw_ext, yaw_c;
  logic signed [SumW-1:0]  base_d;
  mix_t                    lane_mix [MAX_MOTORS];
  logic [PidW+CoefW-1:0]   r_prod [MAX_MOTORS];
  logic [PidW+CoefW-1:0]   p_prod [MAX_MOTORS];
  logic [QuotW-1:0]        r_quo [MAX_MOTORS];
  logic [QuotW-1:0]        p_quo [MAX_MOTORS];
  logic signed [TermW-1:0] rt_d [MAX_MOTORS];
  logic signed [TermW-1:0] pt_d [MAX_MOTORS];
  logic signed [YawW-1:0]  yt_d [MAX_MOTORS];

  always_comb begin
    roll_mag  = s0_roll_q[PidW-1] ? PidW'(-s0_roll_q) : PidW'(s0_roll_q);
    pitch_mag = s0_pitch_q[PidW-1] ? PidW'(-s0_pitch_q) : PidW'(s0_pitch_q);
    ycmd_abs  = s0_ycmd_q[YawCmdW-1] ? YawCmdW'(-s0_ycmd_q) : YawCmdW'(s0_ycmd_q);
    yaw_lim   = $signed(YawW'(ycmd_abs) + YawW'(YawClampBase));
    yaw_ext   = YawW'(s0_yaw_q);
    if (s0_multi_q && (yaw_ext < -yaw_lim)) begin
      yaw_c = -yaw_lim;
    end else if (s0_multi_q && (yaw_ext > yaw_lim)) begin
      yaw_c = yaw_lim;
    end else begin
      yaw_c = yaw_ext;
    end
    base_d = $signed(SumW'(s0_thr_q)) + (SumW'(s0_tpid_q) <<< 1);
    for (int i = 0; i < MAX_MOTORS; i++) begin
      lane_mix[i] = MixTable[s0_frame_q][i];
      r_prod[i]   = roll_mag * ratio_mag(lane_mix[i].rr);
      p_prod[i]   = pitch_mag * ratio_mag(lane_mix[i].pr);
      r_quo[i]    = r_prod[i][FracShift +: QuotW];
      p_quo[i]    = p_prod[i][FracShift +: QuotW];
      rt_d[i]     = (s0_roll_q[PidW-1] ^ lane_mix[i].rneg)
                  ? -$signed(TermW'(r_quo[i])) : $signed(TermW'(r_quo[i]));
      pt_d[i]     = (s0_pitch_q[PidW-1] ^ lane_mix[i].pneg)
                  ? -$signed(TermW'(p_quo[i])) : $signed(TermW'(p_quo[i]));
      if (!lane_mix[i].yen) begin
        yt_d[i] = '0;
      end else if (lane_mix[i].yneg ^ yaw_reverse_q) begin
        yt_d[i] = -yaw_c;
      end else begin
        yt_d[i] = yaw_c;
      end
    end
  end

  logic signed [SumW-1:0]  s1_base_q;
  logic signed [TermW-1:0] s1_rt_q [MAX_MOTORS];
  logic signed [TermW-1:0] s1_pt_q [MAX_MOTORS];
  logic signed [YawW-1:0]  s1_yt_q [MAX_MOTORS];
  logic                    s1_low_q, s1_armed_q;
  logic [LaneIdxW-1:0]     s1_last_q;

  always_ff @(posedge clk_i) begin
    if (v0_q && r1) begin
      s1_base_q  <= base_d;
      s1_rt_q    <= rt_d;
      s1_pt_q    <= pt_d;
      s1_yt_q    <= yt_d;
      s1_low_q   <= s0_low_q;
      s1_armed_q <= s0_armed_q;
      s1_last_q  <= s0_last_q;
    end
  end

  // stage 2: per-motor sums
  logic signed [SumW-1:0] s2_val_q [MAX_MOTORS];
  logic                   s2_low_q, s2_armed_q;
  logic [LaneIdxW-1:0]    s2_last_q;

  always_ff @(posedge clk_i) begin
    if (v1_q && r2) begin
      for (int i = 0; i < MAX_MOTORS; i++) begin
        s2_val_q[i] <= s1_base_q + SumW'(s1_rt_q[i]) + SumW'(s1_pt_q[i])
                     + SumW'(s1_yt_q[i]);
      end
      s2_low_q   <= s1_low_q;
      s2_armed_q <= s1_armed_q;
      s2_last_q  <= s1_last_q;
    end
  end

  // stage 3: largest command over the active motors
  logic signed [SumW-1:0] max_d;

  always_comb begin
    max_d = s2_val_q[0];
    for (int i = 1; i < MAX_MOTORS; i++) begin
      if ((LaneIdxW'(i) <= s2_last_q) && (s2_val_q[i] > max_d)) begin
        max_d = s2_val_q[i];
      end
    end
  end

  logic signed [SumW-1:0] s3_val_q [MAX_MOTORS];
  logic signed [SumW-1:0] s3_max_q;
  logic                   s3_low_q, s3_armed_q;
  logic [LaneIdxW-1:0]    s3_last_q;

  always_ff @(posedge clk_i) begin
    if (v2_q && r3) begin
      s3_val_q   <= s2_val_q;
      s3_max_q   <= max_d;
      s3_low_q   <= s2_low_q;
      s3_armed_q <= s2_armed_q;
      s3_last_q  <= s2_last_q;
    end
  end

  // desaturation, range clamp and overrides
  logic signed [SumW-1:0] lo_s, hi_s, excess;
  logic signed [SumW-1:0] adj [MAX_MOTORS];
  logic [ValueW-1:0]      fin_d [MAX_MOTORS];

  always_comb begin
    lo_s   = $signed(SumW'(min_throttle_q));
    hi_s   = $signed(SumW'(max_throttle_q));
    excess = (s3_max_q > hi_s) ? (s3_max_q - hi_s) : '0;
    for (int i = 0; i < MAX_MOTORS; i++) begin
      adj[i] = s3_val_q[i] - excess;
      if (adj[i] < lo_s) begin
        fin_d[i] = min_throttle_q;
      end else if (adj[i] > hi_s) begin
        fin_d[i] = max_throttle_q;
      end else begin
        fin_d[i] = adj[i][ValueW-1:0];
      end
      if (s3_low_q) begin
        fin_d[i] = motor_stop_q ? stop_command_q : min_throttle_q;
      end
      if (!s3_armed_q) begin
        fin_d[i] = ValueW'(DISARMED_COMMAND);
      end
    end
  end

  // result buffer, drained one motor per cycle while the result side is ready
  logic [ValueW-1:0]   bval_q [MAX_MOTORS];
  logic [LaneIdxW-1:0] blast_q, bidx_q;
  logic                barmed_q;

  always_ff @(posedge clk_i) begin
    if (v3_q && bfree) begin
      bval_q   <= fin_d;
      blast_q  <= s3_last_q;
      barmed_q <= s3_armed_q;
    end
  end

  assign res_last          = (bidx_q == blast_q);
  assign res_o.valid       = bv_q;
  assign res_o.motor_index = IndexW'(bidx_q);
  assign res_o.motor_value = bval_q[bidx_q];
  assign res_o.last_motor  = res_last;

  // valid flags and motor counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q   <= 1'b0;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      bv_q   <= 1'b0;
      bidx_q <= '0;
    end else begin
      if (r0) begin
        v0_q <= req_fire && frame_ok;
      end
      if (r1) begin
        v1_q <= v0_q;
      end
      if (r2) begin
        v2_q <= v1_q;
      end
      if (r3) begin
        v3_q <= v2_q;
      end
      if (bfree) begin
        bv_q   <= v3_q;
        bidx_q <= '0;
      end else if (res_fire) begin
        bidx_q <= bidx_q + LaneIdxW'(1);
      end
    end
  end

  // checks
  `ASSERT_IMPLY(a_idx_in_range, clk_i, rst_ni, bv_q, bidx_q <= blast_q)
  `ASSERT_NEXT(a_idx_restart, clk_i, rst_ni, res_fire && res_last, bidx_q == '0)
  `ASSERT_IMPLY(a_disarmed_value, clk_i, rst_ni, bv_q && !barmed_q,
                res_o.motor_value == ValueW'(DISARMED_COMMAND))
  `ASSERT_NEXT(a_bad_frame_dropped, clk_i, rst_ni, req_fire, v0_q == $past(frame_ok))

endmodule

FILE: bench/mmx_mix_checker.sv
// motor mixer scoreboard: predicts motor commands from taken requests and checks the result channel
`timescale 1ns / 1ps

module mmx_mix_checker (
  input  logic clk_i,
  input  logic rst_ni,
  mmx_req_if   req_mon,
  mmx_res_if   res_mon,
  mmx_cfg_if   cfg_mon,
  output int   fail_count_o,
  output int   outstanding_o
);
  import mmx_pkg::*;

  localparam int PrintCap = 40;

  // one motor's mixing weights: roll rn/rd, pitch pn/pd, yaw sign yz
  typedef struct {
    int rn;
    int rd;
    int pn;
    int pd;
    int yz;
  } weight_t;

  typedef struct packed {
    logic [IndexW-1:0] motor_index;
    logic [ValueW-1:0] motor_value;
    logic              last_motor;
  } motor_cmd_t;

  weight_t frame_mix [NumFrames][MaxMotors];
  int      motors_in_frame [NumFrames] = '{2, 3, 4, 4, 4, 6, 6, 6, 8, 8, 8, 4};

  // shadow copy of the configuration registers
  logic [FrameW-1:0] frame_sel;
  logic              yaw_flip;
  logic [ValueW-1:0] thr_floor;
  logic [ValueW-1:0] thr_ceil;
  logic [ValueW-1:0] stick_floor;
  logic              stop_at_low;
  logic [ValueW-1:0] stop_value;

  motor_cmd_t motor_cmd_q [$];
  motor_cmd_t oldest;
  int         fail_count;
  int         queued;

  assign fail_count_o  = fail_count;
  assign outstanding_o = queued;

  function automatic weight_t w(int rn, int rd, int pn, int pd, int yz);
    weight_t c;
    c.rn = rn;
    c.rd = rd;
    c.pn = pn;
    c.pd = pd;
    c.yz = yz;
    return c;
  endfunction

  // mixing tables per frame
  initial begin
    fail_count = 0;
    // bi
    frame_mix[0][0] = w(1, 1, 0, 1, 0);     frame_mix[0][1] = w(-1, 1, 0, 1, 0);
    // tri
    frame_mix[1][0] = w(0, 1, 4, 3, 0);     frame_mix[1][1] = w(-1, 1, -2, 3, 0);
    frame_mix[1][2] = w(1, 1, -2, 3, 0);
    // quad plus
    frame_mix[2][0] = w(0, 1, 1, 1, -1);    frame_mix[2][1] = w(-1, 1, 0, 1, 1);
    frame_mix[2][2] = w(1, 1, 0, 1, 1);     frame_mix[2][3] = w(0, 1, -1, 1, -1);
    // quad x
    frame_mix[3][0] = w(-1, 1, 1, 1, -1);   frame_mix[3][1] = w(-1, 1, -1, 1, 1);
    frame_mix[3][2] = w(1, 1, 1, 1, 1);     frame_mix[3][3] = w(1, 1, -1, 1, -1);
    // y4
    frame_mix[4][0] = w(0, 1, 1, 1, -1);    frame_mix[4][1] = w(-1, 1, -1, 1, 0);
    frame_mix[4][2] = w(0, 1, 1, 1, 1);     frame_mix[4][3] = w(1, 1, -1, 1, 0);
    // y6
    frame_mix[5][0] = w(0, 1, 4, 3, 1);     frame_mix[5][1] = w(-1, 1, -2, 3, -1);
    frame_mix[5][2] = w(1, 1, -2, 3, -1);   frame_mix[5][3] = w(0, 1, 4, 3, -1);
    frame_mix[5][4] = w(-1, 1, -2, 3, 1);   frame_mix[5][5] = w(1, 1, -2, 3, 1);
    // hex plus
    frame_mix[6][0] = w(-1, 2, 1, 2, 1);    frame_mix[6][1] = w(-1, 2, -1, 2, -1);
    frame_mix[6][2] = w(1, 2, 1, 2, 1);     frame_mix[6][3] = w(1, 2, -1, 2, -1);
    frame_mix[6][4] = w(0, 1, -1, 1, 1);    frame_mix[6][5] = w(0, 1, 1, 1, -1);
    // hex x
    frame_mix[7][0] = w(-4, 5, 9, 10, 1);   frame_mix[7][1] = w(-4, 5, -9, 10, 1);
    frame_mix[7][2] = w(4, 5, 9, 10, -1);   frame_mix[7][3] = w(4, 5, -9, 10, -1);
    frame_mix[7][4] = w(-4, 5, 0, 1, -1);   frame_mix[7][5] = w(4, 5, 0, 1, 1);
    // octo x8
    frame_mix[8][0] = w(-1, 1, 1, 1, -1);   frame_mix[8][1] = w(-1, 1, -1, 1, 1);
    frame_mix[8][2] = w(1, 1, 1, 1, 1);     frame_mix[8][3] = w(1, 1, -1, 1, -1);
    frame_mix[8][4] = w(-1, 1, 1, 1, 1);    frame_mix[8][5] = w(-1, 1, -1, 1, -1);
    frame_mix[8][6] = w(1, 1, 1, 1, -1);    frame_mix[8][7] = w(1, 1, -1, 1, 1);
    // octo flat plus
    frame_mix[9][0] = w(7, 10, -7, 10, 1);  frame_mix[9][1] = w(-7, 10, -7, 10, 1);
    frame_mix[9][2] = w(-7, 10, 7, 10, 1);  frame_mix[9][3] = w(7, 10, 7, 10, 1);
    frame_mix[9][4] = w(0, 1, -1, 1, -1);   frame_mix[9][5] = w(-1, 1, 0, 1, -1);
    frame_mix[9][6] = w(0, 1, 1, 1, -1);    frame_mix[9][7] = w(1, 1, 0, 1, -1);
    // octo flat x
    frame_mix[10][0] = w(1, 1, -1, 2, 1);   frame_mix[10][1] = w(-1, 2, -1, 1, 1);
    frame_mix[10][2] = w(-1, 1, 1, 2, 1);   frame_mix[10][3] = w(1, 2, 1, 1, 1);
    frame_mix[10][4] = w(1, 2, -1, 1, -1);  frame_mix[10][5] = w(-1, 1, -1, 2, -1);
    frame_mix[10][6] = w(-1, 2, 1, 1, -1);  frame_mix[10][7] = w(1, 1, 1, 2, -1);
    // vtail4
    frame_mix[11][0] = w(0, 1, 1, 1, 1);    frame_mix[11][1] = w(-1, 1, -1, 1, 0);
    frame_mix[11][2] = w(0, 1, 1, 1, -1);   frame_mix[11][3] = w(1, 1, -1, 1, 0);
  end

  // low bound tested first, so an inverted range gives the low bound below it and the high bound otherwise
  function automatic int clip(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic report_mismatch(input string what);
    if (fail_count < PrintCap) $display("[%0t] motor mixer mismatch: %s", $time, what);
    fail_count++;
  endtask

  // expected motor commands of one control update
  function automatic void mix_update(input int thr, tpid, roll, pitch, yaw, ycmd, stick,
                                     input bit armed);
    int         n;
    int         span;
    int         peak;
    int         v;
    int         lo;
    int         hi;
    int         dir;
    int         raw [MaxMotors];
    weight_t    c;
    motor_cmd_t cmd;
    if (frame_sel >= NumFrames) return;
    n = motors_in_frame[frame_sel];
    // anti yaw jump clamp on frames with more than three motors
    if (n > 3) begin
      span = YawClampBase + ((ycmd < 0) ? -ycmd : ycmd);
      yaw  = clip(yaw, -span, span);
    end
    if (n > MaxMotors) n = MaxMotors;
    dir = yaw_flip ? -1 : 1;
    lo  = int'(thr_floor);
    hi  = int'(thr_ceil);
    for (int i = 0; i < n; i++) begin
      c      = frame_mix[frame_sel][i];
      raw[i] = thr + tpid + tpid + (roll * c.rn) / c.rd + (pitch * c.pn) / c.pd
               + dir * yaw * c.yz;
    end
    peak = raw[0];
    for (int i = 1; i < n; i++) begin
      if (raw[i] > peak) peak = raw[i];
    end
    // desaturate, clamp, then the low stick and disarmed overrides
    for (int i = 0; i < n; i++) begin
      v = raw[i];
      if (peak > hi) v = v - (peak - hi);
      v = clip(v, lo, hi);
      if (stick < int'(stick_floor)) v = stop_at_low ? int'(stop_value) : lo;
      if (!armed) v = DisarmedCommand;
      cmd.motor_index = IndexW'(i);
      cmd.motor_value = ValueW'(v);
      cmd.last_motor  = (i == n - 1);
      motor_cmd_q.push_back(cmd);
    end
  endfunction

  // watch the three channels at each clock edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      motor_cmd_q.delete();
      frame_sel   = FrameTypeRst;
      yaw_flip    = 1'b0;
      thr_floor   = MinThrottleRst;
      thr_ceil    = MaxThrottleRst;
      stick_floor = MinCheckRst;
      stop_at_low = 1'b0;
      stop_value  = StopCommandRst;
      queued      <= 0;
    end else begin
      // register writes
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          RegFrameType:   frame_sel   = FrameW'(cfg_mon.data);
          RegYawReverse:  yaw_flip    = cfg_mon.data[0];
          RegMinThrottle: thr_floor   = ValueW'(cfg_mon.data);
          RegMaxThrottle: thr_ceil    = ValueW'(cfg_mon.data);
          RegMinCheck:    stick_floor = ValueW'(cfg_mon.data);
          RegMotorStop:   stop_at_low = cfg_mon.data[0];
          RegStopCommand: stop_value  = ValueW'(cfg_mon.data);
          default: ;
        endcase
      end
      // motor command against the oldest expectation
      if (res_mon.valid && res_mon.ready) begin
        if (motor_cmd_q.size() == 0) begin
          report_mismatch($sformatf("motor %0d value %0d last %0b with nothing pending",
                                    res_mon.motor_index, res_mon.motor_value,
                                    res_mon.last_motor));
        end else begin
          oldest = motor_cmd_q.pop_front();
          if (res_mon.motor_index !== oldest.motor_index)
            report_mismatch($sformatf("motor_index %0d, expected %0d",
                                      res_mon.motor_index, oldest.motor_index));
          if (res_mon.motor_value !== oldest.motor_value)
            report_mismatch($sformatf("motor %0d motor_value %0d, expected %0d",
                                      oldest.motor_index, res_mon.motor_value,
                                      oldest.motor_value));
          if (res_mon.last_motor !== oldest.last_motor)
            report_mismatch($sformatf("motor %0d last_motor %0b, expected %0b",
                                      oldest.motor_index, res_mon.last_motor,
                                      oldest.last_motor));
        end
      end
      // new control update
      if (req_mon.valid && req_mon.ready) begin
        mix_update(int'(req_mon.throttle_command), int'($signed(req_mon.throttle_pid)),
                   int'($signed(req_mon.roll_pid)), int'($signed(req_mon.pitch_pid)),
                   int'($signed(req_mon.yaw_pid)), int'($signed(req_mon.yaw_command)),
                   int'(req_mon.stick_throttle), req_mon.armed);
      end
      queued <= motor_cmd_q.size();
    end
  end

endmodule

FILE: bench/multirotor_motor_mixer_test.sv
// motor mixer testbench top: drives updates, register writes and result stalls, gives the verdict
`timescale 1ns / 1ps

module multirotor_motor_mixer_test;
  import mmx_pkg::*;

  localparam int CycleLimit   = 200000;
  localparam int SettleCycles = 20;
  localparam int HoldCycles   = 300;
  localparam int IdlePct      = 17;
  localparam int Phases       = 16;
  localparam logic [CfgIdxW-1:0] RegUnused = CfgIdxW'(7);

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   outstanding;
  int   cycle_count = 0;
  bit   calm;
  bit   hold_results;
  int   cur_min_check;

  mmx_req_if req_bus ();
  mmx_res_if res_bus ();
  mmx_cfg_if cfg_bus ();

  multirotor_motor_mixer u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .req_i  (req_bus),
    .res_o  (res_bus)
  );

  mmx_mix_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_mon       (req_bus),
    .res_mon       (res_bus),
    .cfg_mon       (cfg_bus),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  // 100 MHz clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result side back pressure
  initial begin
    res_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      res_bus.ready <= !hold_results && (calm || $urandom_range(0, 99) >= IdlePct);
    end
  end

  // long result stall so the block fills and stalls its requests
  task automatic stall_results();
    hold_results <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_results <= 1'b0;
  endtask

  function automatic int spread(int m);
    return int'($urandom_range(0, 2 * m)) - m;
  endfunction

  // one request, held until taken
  task automatic send_update(input int thr, tpid, roll, pitch, yaw, ycmd, stick,
                             input bit armed_now);
    while (!calm && $urandom_range(0, 99) < IdlePct) begin
      req_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_bus.valid            <= 1'b1;
    req_bus.throttle_command <= ValueW'(thr);
    req_bus.throttle_pid     <= PidW'(tpid);
    req_bus.roll_pid         <= PidW'(roll);
    req_bus.pitch_pid        <= PidW'(pitch);
    req_bus.yaw_pid          <= PidW'(yaw);
    req_bus.yaw_command      <= YawCmdW'(ycmd);
    req_bus.stick_throttle   <= ValueW'(stick);
    req_bus.armed            <= armed_now;
    do @(posedge clk_i); while (!req_bus.ready);
  endtask

  // flight-like updates mostly, full-range noise for the rest
  task automatic send_random_update();
    int pick;
    int stick;
    pick = $urandom_range(0, 99);
    if (pick < 75) begin
      stick = ($urandom_range(0, 99) < 90) ? $urandom_range(cur_min_check, 2047)
                                           : $urandom_range(0, 2047);
      send_update($urandom_range(1000, 1950), spread(150), spread(400), spread(400),
                  spread(300), spread(512) % 512, stick, $urandom_range(0, 99) < 95);
    end else begin
      send_update($urandom_range(0, 2047), spread(1024) % 1024, spread(1024) % 1024,
                  spread(1024) % 1024, spread(1024) % 1024, spread(512) % 512,
                  $urandom_range(0, 2047), $urandom_range(0, 1));
    end
  endtask

  // drop the request, wait for every pending command, let the pipeline empty
  task automatic settle();
    req_bus.valid <= 1'b0;
    @(posedge clk_i);
    wait (outstanding == 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= CfgDataW'(value);
    do @(posedge clk_i); while (!cfg_bus.ready);
  endtask

  // full register set; narrow registers get random upper data bits
  task automatic apply_settings(input int frame, rev, lo, hi, chk, stop_en, stop_val);
    write_reg(RegFrameType, frame | (int'($urandom_range(0, 127)) << FrameW));
    write_reg(RegYawReverse, rev | (int'($urandom_range(0, 1023)) << 1));
    write_reg(RegMinThrottle, lo);
    write_reg(RegMaxThrottle, hi);
    write_reg(RegMinCheck, chk);
    write_reg(RegMotorStop, stop_en | (int'($urandom_range(0, 1023)) << 1));
    write_reg(RegStopCommand, stop_val);
    cfg_bus.valid <= 1'b0;
    cur_min_check = chk;
    @(posedge clk_i);
  endtask

  task automatic run_updates(input int count, input bit pause_mid);
    for (int i = 0; i < count; i++) begin
      if (pause_mid && i == count / 2) settle();
      send_random_update();
    end
  endtask

  initial begin
    int frame;
    int lo_thr;
    int hi_thr;
    int chk;
    int stop_val;
    rst_ni                   <= 1'b0;
    req_bus.valid            <= 1'b0;
    req_bus.throttle_command <= '0;
    req_bus.throttle_pid     <= '0;
    req_bus.roll_pid         <= '0;
    req_bus.pitch_pid        <= '0;
    req_bus.yaw_pid          <= '0;
    req_bus.yaw_command      <= '0;
    req_bus.stick_throttle   <= '0;
    req_bus.armed            <= 1'b0;
    cfg_bus.valid            <= 1'b0;
    cfg_bus.index            <= '0;
    cfg_bus.data             <= '0;
    cur_min_check = MinCheckRst;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset settings, quad x
    send_update(1500, 0, 0, 0, 0, 0, 2000, 1'b1);
    send_update(0, -1024, -1024, -1024, -1024, -512, 2047, 1'b1);
    send_update(2047, 1023, 1023, 1023, 1023, 511, 2047, 1'b1);
    // yaw clamp at the base width and at the widest
    send_update(1500, 0, 0, 0, 1023, 0, 1500, 1'b1);
    send_update(1500, 0, 0, 0, -1024, -512, 1500, 1'b1);
    // stick just below and at min_check
    send_update(1500, 0, 300, -300, 50, 0, 1099, 1'b1);
    send_update(1500, 0, 300, -300, 50, 0, 1100, 1'b1);
    // disarmed, also over low stick
    send_update(1500, 0, 0, 0, 0, 0, 1500, 1'b0);
    send_update(1500, 0, 0, 0, 0, 0, 0, 1'b0);
    send_update(1800, 200, 500, 0, 0, 0, 1500, 1'b1);
    settle();

    // stop command at low stick, inverted throttle range, unused register index
    write_reg(RegUnused, 'h5A5);
    apply_settings(3, 0, 2000, 100, 1100, 1, 2047);
    send_update(1500, 0, 0, 0, 0, 0, 0, 1'b1);
    send_update(1500, 0, 0, 0, 0, 0, 2047, 1'b1);
    send_update(2047, 1023, 1023, 1023, 1023, 511, 2047, 1'b1);
    settle();

    // unused frame code gives no commands
    apply_settings(15, 1, 1150, 1850, 1100, 0, 1000);
    send_update(1500, 10, 20, 30, 40, 50, 2000, 1'b1);
    send_update(1500, 0, 0, 0, 0, 0, 0, 1'b0);
    settle();

    // fractional weights with negative truncation
    apply_settings(10, 1, 0, 2047, 0, 0, 0);
    send_update(1000, -37, 333, -777, 201, -5, 2047, 1'b1);
    send_update(1000, 11, -1001, 999, -300, 100, 0, 1'b1);
    settle();
    apply_settings(1, 0, 0, 2047, 0, 0, 0);
    send_update(1200, 5, -13, -1000, 9, 0, 2047, 1'b1);
    settle();
    apply_settings(7, 0, 0, 2047, 0, 0, 0);
    send_update(1200, 5, -13, 17, 9, 0, 2047, 1'b1);

    // random phases, one register set each
    for (int phase = 0; phase < Phases; phase++) begin
      settle();
      if (phase < NumFrames) frame = phase;
      else if (phase == NumFrames) frame = NumFrames + $urandom_range(0, 3);
      else frame = $urandom_range(0, NumFrames - 1);
      stop_val = $urandom_range(0, 2047);
      case (phase % 4)
        0: begin
          lo_thr = $urandom_range(950, 1200);
          hi_thr = $urandom_range(1750, 2047);
          chk    = $urandom_range(1000, 1200);
        end
        1: begin
          lo_thr   = 0;
          hi_thr   = 2047;
          chk      = $urandom_range(900, 1200);
          stop_val = 0;
        end
        2: begin
          lo_thr = $urandom_range(0, 2047);
          hi_thr = $urandom_range(0, 2047);
          chk    = $urandom_range(0, 2047);
        end
        default: begin
          lo_thr = $urandom_range(1500, 2047);
          hi_thr = $urandom_range(0, 1400);
          chk    = (phase % 8 == 3) ? 0 : 2047;
        end
      endcase
      apply_settings(frame, $urandom_range(0, 1), lo_thr, hi_thr, chk,
                     $urandom_range(0, 1), stop_val);
      calm = (phase == 5);
      if (phase == 2) begin
        fork
          stall_results();
          run_updates(40, 1'b0);
        join
      end else begin
        run_updates((frame >= NumFrames) ? 6 : 26, phase == 7);
      end
      calm = 1'b0;
    end

    settle();
    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
